>>> rtl/spa_pkg.sv
// spa_pkg: shared types and constants for the sliding piece attack generator
// ray step directions for the diagonal and orthogonal sliders
// no dependencies
`default_nettype none

package spa_pkg;

  localparam int BOARD_W  = 64;
  localparam int SQUARE_W = 6;
  localparam int RAY_DIRS = 4;
  localparam int RAY_LEN  = 7;

  localparam logic KIND_DIAG = 1'b0;
  localparam logic KIND_ORTH = 1'b1;

  typedef struct packed {
    logic signed [1:0] dr;
    logic signed [1:0] df;
  } dir_t;

  typedef dir_t dir_set_t [RAY_DIRS];

  localparam dir_set_t DIAG_DIRS = '{
    '{dr: 2'sd1,  df: 2'sd1},
    '{dr: 2'sd1,  df: -2'sd1},
    '{dr: -2'sd1, df: 2'sd1},
    '{dr: -2'sd1, df: -2'sd1}
  };

  localparam dir_set_t ORTH_DIRS = '{
    '{dr: 2'sd1,  df: 2'sd0},
    '{dr: -2'sd1, df: 2'sd0},
    '{dr: 2'sd0,  df: 2'sd1},
    '{dr: 2'sd0,  df: -2'sd1}
  };

endpackage

`default_nettype wire

>>> rtl/spa_ray.sv
// spa_ray: scans one ray outward from a square, stopping at the first blocker
// depends on spa_pkg for the direction type and board sizes
`default_nettype none

module spa_ray
  import spa_pkg::*;
(
  input  wire logic [SQUARE_W-1:0] square,
  input  wire dir_t                dir,
  input  wire logic [BOARD_W-1:0]  occupancy,
  output logic      [BOARD_W-1:0]  ray
);

  logic signed [4:0] r;
  logic signed [4:0] f;
  logic              active;
  logic [SQUARE_W-1:0] idx;

  always_comb begin
    ray    = '0;
    r      = {2'b00, square[5:3]};
    f      = {2'b00, square[2:0]};
    active = 1'b1;
    idx    = '0;
    for (int i = 0; i < RAY_LEN; i++) begin
      r = r + {{3{dir.dr[1]}}, dir.dr};
      f = f + {{3{dir.df[1]}}, dir.df};
      idx = {r[2:0], f[2:0]};
      if (r[4:3] != 2'b00 || f[4:3] != 2'b00) begin
        active = 1'b0;
      end
      if (active) begin
        ray[idx] = 1'b1;
        if (occupancy[idx]) begin
          active = 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/sliding_piece_attack_generator.sv
// sliding_piece_attack_generator: bishop or rook attack set from square and occupancy
// the word passes the input register, then the result register and done strobe; one word per cycle
// busy stays low, so a word can be started every cycle; the receiver cannot stall
// rate set by one input register and one result register around four ray scanners
// synchronous active-high reset clears the valid pipeline, payload is not reset
// depends on spa_pkg and spa_ray
`default_nettype none

module sliding_piece_attack_generator
  import spa_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                req_type,
  input  wire logic [SQUARE_W-1:0] piece_square,
  input  wire logic [BOARD_W-1:0]  occupancy,
  output logic                     done,
  output logic      [BOARD_W-1:0]  attack_set
);

  logic                s1_valid;
  logic                s1_type;
  logic [SQUARE_W-1:0] s1_square;
  logic [BOARD_W-1:0]  s1_occ;

  logic [BOARD_W-1:0]  rays [RAY_DIRS];
  logic [BOARD_W-1:0]  attack_set_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      done     <= s1_valid;
    end
    if (start && !busy) begin
      s1_type   <= req_type;
      s1_square <= piece_square;
      s1_occ    <= occupancy;
    end
    if (s1_valid) begin
      attack_set <= attack_set_next;
    end
  end

  for (genvar d = 0; d < RAY_DIRS; d++) begin : g_ray
    dir_t dir;
    assign dir = (s1_type == KIND_ORTH) ? ORTH_DIRS[d] : DIAG_DIRS[d];
    spa_ray u_ray (
      .square    (s1_square),
      .dir       (dir),
      .occupancy (s1_occ),
      .ray       (rays[d])
    );
  end

  always_comb begin
    attack_set_next = '0;
    for (int d = 0; d < RAY_DIRS; d++) begin
      attack_set_next = attack_set_next | rays[d];
    end
  end

  a_start_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("done strobe missing two cycles after start");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(s1_valid))
    else $error("done without a word in the input register");

  a_own_square: assert property (@(posedge clk) disable iff (rst)
    done |-> !attack_set[$past(s1_square)])
    else $error("attack set holds the piece square");

  a_max_count: assert property (@(posedge clk) disable iff (rst)
    done |-> ($countones(attack_set) <= 14))
    else $error("attack set larger than any slider can reach");

endmodule

`default_nettype wire

>>> bench/sliding_piece_attack_generator_tb.sv
// sliding_piece_attack_generator_tb: self-checking bench for the bishop/rook attack generator
// queue-fed driver with random gaps, strobe monitor checked against a ray-scan predictor
// depends on spa_pkg and the sliding_piece_attack_generator rtl
`timescale 1ns / 1ps

module sliding_piece_attack_generator_tb;
  import spa_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_WORDS = 550;

  typedef struct {
    logic                kind;
    logic [SQUARE_W-1:0] square;
    logic [BOARD_W-1:0]  occ;
    int                  gap;
    bit                  drain;
  } attack_word_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                req_type;
  logic [SQUARE_W-1:0] piece_square;
  logic [BOARD_W-1:0]  occupancy;
  logic                done;
  logic [BOARD_W-1:0]  attack_set;

  attack_word_t word_q[$];
  attack_word_t attack_q[$];
  attack_word_t cur_word;
  int           wait_cnt;
  int           err_count;
  int           cycle_count;

  sliding_piece_attack_generator u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .piece_square (piece_square),
    .occupancy    (occupancy),
    .done         (done),
    .attack_set   (attack_set)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [BOARD_W-1:0] slider_attacks(logic kind, logic [SQUARE_W-1:0] sq,
                                                       logic [BOARD_W-1:0] occ);
    logic [BOARD_W-1:0] att;
    int r0, f0, r, f, dr, df;
    bit blocked;
    att = '0;
    r0 = int'(sq[5:3]);
    f0 = int'(sq[2:0]);
    for (int d = 0; d < 4; d++) begin
      if (kind == KIND_DIAG) begin
        dr = (d < 2) ? 1 : -1;
        df = (d % 2 == 0) ? 1 : -1;
      end else begin
        dr = (d == 0) ? 1 : ((d == 1) ? -1 : 0);
        df = (d == 2) ? 1 : ((d == 3) ? -1 : 0);
      end
      r = r0 + dr;
      f = f0 + df;
      blocked = 1'b0;
      while (!blocked && r >= 0 && r <= 7 && f >= 0 && f <= 7) begin
        att[6'(r*8+f)] = 1'b1;
        if (occ[6'(r*8+f)]) blocked = 1'b1;
        r += dr;
        f += df;
      end
    end
    return att;
  endfunction

  function automatic logic [BOARD_W-1:0] rand_board();
    logic [BOARD_W-1:0] b;
    int n;
    b = '0;
    case ($urandom_range(0, 3))
      0: b = {$urandom, $urandom};
      1: begin
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) b[6'($urandom_range(0, 63))] = 1'b1;
      end
      2: begin
        n = $urandom_range(0, 6);
        b = '1;
        for (int i = 0; i < n; i++) b[6'($urandom_range(0, 63))] = 1'b0;
      end
      default: b = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
    return b;
  endfunction

  task automatic add_word(logic kind, logic [SQUARE_W-1:0] sq, logic [BOARD_W-1:0] occ,
                          int gap, bit drain);
    attack_word_t w;
    w.kind   = kind;
    w.square = sq;
    w.occ    = occ;
    w.gap    = gap;
    w.drain  = drain;
    word_q.push_back(w);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      wait_cnt <= 0;
    end else begin
      if (start && !busy) attack_q.push_back(cur_word);
      if (!(start && busy)) begin
        if (word_q.size() == 0) begin
          start <= 1'b0;
        end else if (wait_cnt < word_q[0].gap) begin
          wait_cnt <= wait_cnt + 1;
          start <= 1'b0;
        end else if (word_q[0].drain && attack_q.size() != 0) begin
          start <= 1'b0;
        end else begin
          cur_word = word_q.pop_front();
          wait_cnt <= 0;
          start <= 1'b1;
          req_type <= cur_word.kind;
          piece_square <= cur_word.square;
          occupancy <= cur_word.occ;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    attack_word_t exp_word;
    logic [BOARD_W-1:0] exp_att;
    if (!rst && done) begin
      if (attack_q.size() == 0) begin
        err_count <= err_count + 1;
        if (err_count < MAX_REPORTS)
          $display("unexpected word: attack_set %h", attack_set);
      end else begin
        exp_word = attack_q.pop_front();
        exp_att = slider_attacks(exp_word.kind, exp_word.square, exp_word.occ);
        if (attack_set !== exp_att) begin
          err_count <= err_count + 1;
          if (err_count < MAX_REPORTS)
            $display("mismatch: kind %0d square %0d occ %h expected %h actual %h",
                     exp_word.kind, exp_word.square, exp_word.occ, exp_att, attack_set);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [SQUARE_W-1:0] sq;
    logic [BOARD_W-1:0]  occ;
    int burst;
    rst = 1'b1;
    start = 1'b0;
    req_type = 1'b0;
    piece_square = '0;
    occupancy = '0;
    err_count = 0;
    cycle_count = 0;
    wait_cnt = 0;

    // corners, center, empty and full boards, own-square bit
    add_word(KIND_ORTH, 6'd0,  64'h0, 0, 1'b0);
    add_word(KIND_DIAG, 6'd0,  64'h0, 0, 1'b0);
    add_word(KIND_ORTH, 6'd63, 64'h0, 0, 1'b0);
    add_word(KIND_DIAG, 6'd63, 64'h0, 0, 1'b0);
    add_word(KIND_ORTH, 6'd7,  '1, 1, 1'b0);
    add_word(KIND_DIAG, 6'd7,  '1, 0, 1'b0);
    add_word(KIND_ORTH, 6'd56, '1, 0, 1'b0);
    add_word(KIND_DIAG, 6'd56, '1, 2, 1'b0);
    add_word(KIND_ORTH, 6'd27, 64'h0, 0, 1'b0);
    add_word(KIND_DIAG, 6'd27, 64'h0, 0, 1'b0);
    add_word(KIND_ORTH, 6'd36, '1, 0, 1'b0);
    add_word(KIND_DIAG, 6'd36, '1, 0, 1'b0);
    add_word(KIND_ORTH, 6'd27, 64'h1 << 27, 0, 1'b0);
    add_word(KIND_DIAG, 6'd27, 64'h1 << 27, 0, 1'b0);
    add_word(KIND_ORTH, 6'd27, ~(64'h1 << 27), 3, 1'b1);
    add_word(KIND_DIAG, 6'd27, ~(64'h1 << 27), 0, 1'b0);
    add_word(KIND_ORTH, 6'd20, 64'haaaa_aaaa_aaaa_aaaa, 0, 1'b0);
    add_word(KIND_DIAG, 6'd20, 64'h5555_5555_5555_5555, 0, 1'b0);
    add_word(KIND_ORTH, 6'd42, 64'hff00_0000_0000_00ff, 4, 1'b0);
    add_word(KIND_DIAG, 6'd9,  64'h8100_0000_0000_0081, 0, 1'b0);
    add_word(KIND_ORTH, 6'd0,  64'h8000_0000_0000_0080, 0, 1'b0);
    add_word(KIND_DIAG, 6'd63, 64'h0000_0000_0000_0001, 0, 1'b1);

    burst = 0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (burst == 0 && $urandom_range(0, 9) == 0) burst = $urandom_range(5, 20);
      sq = SQUARE_W'($urandom_range(0, 63));
      occ = rand_board();
      if ($urandom_range(0, 3) == 0) occ[sq] = 1'b1;
      add_word(1'($urandom_range(0, 1)), sq, occ, (burst > 0) ? 0 : $urandom_range(0, 4),
               ($urandom_range(0, 49) == 0));
      if (burst > 0) burst--;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (word_q.size() != 0 || start) @(posedge clk);
    while (attack_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
